>>> design/abvpp_pkg.sv
// Shared types, constants and helper functions of the alpha blend pixel packer.
package abvpp_pkg;

    // Width of the packed device pixel that is kept; the result field itself is 32 bits.
    localparam int PIXEL_WORD_BITS = 32;

    localparam int NUM_CHAN     = 3;
    localparam int CHAN_BITS    = 8;
    localparam int MASK_BITS    = 32;
    localparam int SHIFT_BITS   = 5;
    localparam int BLEND_BITS   = 16;
    localparam int FQ_BITS      = 25;
    localparam int CFG_IDX_BITS = 3;

    // Channel order inside every per-channel array.
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    localparam logic [CHAN_BITS-1:0] CHAN_MAX = 8'd255;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_RED_MASK   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GREEN_MASK = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BLUE_MASK  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BG_RED     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BG_GREEN   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BG_BLUE    = 3'd5;

    localparam logic [MASK_BITS-1:0] RST_RED_MASK   = 32'h00FF_0000;
    localparam logic [MASK_BITS-1:0] RST_GREEN_MASK = 32'h0000_FF00;
    localparam logic [MASK_BITS-1:0] RST_BLUE_MASK  = 32'h0000_00FF;
    localparam logic [CHAN_BITS-1:0] RST_BG         = 8'd0;

    // Bits of the packed word that survive the pixel word width.
    localparam logic [MASK_BITS-1:0] WORD_KEEP = (PIXEL_WORD_BITS >= MASK_BITS) ?
        {MASK_BITS{1'b1}} : MASK_BITS'((64'd1 << PIXEL_WORD_BITS) - 64'd1);

    // Per-channel placement values, derived from one field mask.
    // fq and fr are the quotient and remainder of the right-aligned field by 255.
    typedef struct packed {
        logic [MASK_BITS-1:0]  mask;
        logic [SHIFT_BITS-1:0] shift;
        logic [FQ_BITS-1:0]    fq;
        logic [CHAN_BITS-1:0]  fr;
    } t_chan_cfg;

    // Exact floor(x / 255) for x up to 255 * 255.
    function automatic logic [CHAN_BITS-1:0] div255(input logic [BLEND_BITS-1:0] x);
        logic [BLEND_BITS:0] s;
        s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return s[15:8];
    endfunction

endpackage

>>> design/abvpp_cfg.sv
// Configuration registers and the placement values derived from the field masks.
module abvpp_cfg (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_cfg_we,
    input  logic [abvpp_pkg::CFG_IDX_BITS-1:0]              i_cfg_idx,
    input  logic [abvpp_pkg::MASK_BITS-1:0]                 i_cfg_wdata,
    output logic [abvpp_pkg::NUM_CHAN-1:0][abvpp_pkg::CHAN_BITS-1:0] o_bg,
    output abvpp_pkg::t_chan_cfg [abvpp_pkg::NUM_CHAN-1:0]  o_place
);

    logic [abvpp_pkg::NUM_CHAN-1:0][abvpp_pkg::MASK_BITS-1:0]  r_mask;
    logic [abvpp_pkg::NUM_CHAN-1:0][abvpp_pkg::CHAN_BITS-1:0]  r_bg;
    logic [abvpp_pkg::NUM_CHAN-1:0][abvpp_pkg::SHIFT_BITS-1:0] r_shift;
    logic [abvpp_pkg::NUM_CHAN-1:0][abvpp_pkg::MASK_BITS-1:0]  r_field;
    logic [abvpp_pkg::NUM_CHAN-1:0][abvpp_pkg::FQ_BITS-1:0]    r_fq;
    logic [abvpp_pkg::NUM_CHAN-1:0][abvpp_pkg::CHAN_BITS-1:0]  r_fr;

    logic [abvpp_pkg::NUM_CHAN-1:0][abvpp_pkg::SHIFT_BITS-1:0] n_shift;
    logic [abvpp_pkg::NUM_CHAN-1:0][abvpp_pkg::MASK_BITS-1:0]  n_field;
    logic [abvpp_pkg::NUM_CHAN-1:0][abvpp_pkg::FQ_BITS-1:0]    n_fq;
    logic [abvpp_pkg::NUM_CHAN-1:0][abvpp_pkg::CHAN_BITS-1:0]  n_fr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask[abvpp_pkg::CH_RED]   <= abvpp_pkg::RST_RED_MASK;
            r_mask[abvpp_pkg::CH_GREEN] <= abvpp_pkg::RST_GREEN_MASK;
            r_mask[abvpp_pkg::CH_BLUE]  <= abvpp_pkg::RST_BLUE_MASK;
            r_bg[abvpp_pkg::CH_RED]     <= abvpp_pkg::RST_BG;
            r_bg[abvpp_pkg::CH_GREEN]   <= abvpp_pkg::RST_BG;
            r_bg[abvpp_pkg::CH_BLUE]    <= abvpp_pkg::RST_BG;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                abvpp_pkg::CFG_RED_MASK:   r_mask[abvpp_pkg::CH_RED]   <= i_cfg_wdata;
                abvpp_pkg::CFG_GREEN_MASK: r_mask[abvpp_pkg::CH_GREEN] <= i_cfg_wdata;
                abvpp_pkg::CFG_BLUE_MASK:  r_mask[abvpp_pkg::CH_BLUE]  <= i_cfg_wdata;
                abvpp_pkg::CFG_BG_RED:     r_bg[abvpp_pkg::CH_RED]     <= i_cfg_wdata[7:0];
                abvpp_pkg::CFG_BG_GREEN:   r_bg[abvpp_pkg::CH_GREEN]   <= i_cfg_wdata[7:0];
                abvpp_pkg::CFG_BG_BLUE:    r_bg[abvpp_pkg::CH_BLUE]    <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // First step: position of the lowest set bit and the right-aligned field.
    // An all-zero mask gives a shift of zero and an empty field.
    always_comb begin
        logic [abvpp_pkg::MASK_BITS-1:0] low;
        for (int c = 0; c < abvpp_pkg::NUM_CHAN; c++) begin
            low        = r_mask[c] & (~r_mask[c] + 32'd1);
            n_shift[c] = '0;
            for (int i = 0; i < abvpp_pkg::MASK_BITS; i++) begin
                for (int k = 0; k < abvpp_pkg::SHIFT_BITS; k++) begin
                    if (((i >> k) & 1) == 1) begin
                        n_shift[c][k] = n_shift[c][k] | low[i];
                    end
                end
            end
            n_field[c] = r_mask[c] >> n_shift[c];
        end
    end

    // Second step: field / 255 by a reciprocal built from shifts, and field mod 255
    // by folding bytes, since 256 leaves a remainder of one.
    always_comb begin
        logic [65:0] acc;
        logic [9:0]  bsum;
        logic [8:0]  fold;
        for (int c = 0; c < abvpp_pkg::NUM_CHAN; c++) begin
            acc = ({34'd0, r_field[c]} << 32) + ({34'd0, r_field[c]} << 24)
                + ({34'd0, r_field[c]} << 16) + ({34'd0, r_field[c]} << 8)
                + ({34'd0, r_field[c]} << 1);
            n_fq[c] = acc[64:40];
            bsum = {2'd0, r_field[c][7:0]} + {2'd0, r_field[c][15:8]}
                 + {2'd0, r_field[c][23:16]} + {2'd0, r_field[c][31:24]};
            fold = {1'b0, bsum[7:0]} + {7'd0, bsum[9:8]};
            if (fold >= 9'd255) begin
                n_fr[c] = 8'(fold - 9'd255);
            end else begin
                n_fr[c] = fold[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_field <= n_field;
        r_fq    <= n_fq;
        r_fr    <= n_fr;
    end

    always_comb begin
        for (int c = 0; c < abvpp_pkg::NUM_CHAN; c++) begin
            o_place[c].mask  = r_mask[c];
            o_place[c].shift = r_shift[c];
            o_place[c].fq    = r_fq[c];
            o_place[c].fr    = r_fr[c];
        end
    end

    assign o_bg = r_bg;

endmodule

>>> design/abvpp_blend.sv
// Alpha and blend pipeline: alpha from the mask pixel, blend, divide by 255.
module abvpp_blend (
    input  logic                                                     i_clk,
    input  logic                                                     i_rst_n,
    input  logic                                                     i_vld,
    input  logic [abvpp_pkg::NUM_CHAN-1:0][abvpp_pkg::CHAN_BITS-1:0] i_src,
    input  logic                                                     i_present,
    input  logic [abvpp_pkg::NUM_CHAN-1:0][abvpp_pkg::CHAN_BITS-1:0] i_opac,
    input  logic [abvpp_pkg::NUM_CHAN-1:0][abvpp_pkg::CHAN_BITS-1:0] i_bg,
    input  logic                                                     i_rdy,
    output logic                                                     o_rdy,
    output logic                                                     o_vld,
    output logic [abvpp_pkg::NUM_CHAN-1:0][abvpp_pkg::CHAN_BITS-1:0] o_val
);

    // floor(sum / 3) == (sum * 683) >> 11 for every sum below 2048.
    localparam logic [9:0] RECIP3       = 10'd683;
    localparam int         RECIP3_SHIFT = 11;

    logic r1_vld, r2_vld, r3_vld;
    logic en1, en2, en3;

    logic [abvpp_pkg::NUM_CHAN-1:0][abvpp_pkg::CHAN_BITS-1:0]  r1_c;
    logic [abvpp_pkg::CHAN_BITS-1:0]                           r1_alpha;
    logic [abvpp_pkg::NUM_CHAN-1:0][abvpp_pkg::BLEND_BITS-1:0] r2_t;
    logic [abvpp_pkg::NUM_CHAN-1:0][abvpp_pkg::CHAN_BITS-1:0]  r3_v;

    logic [abvpp_pkg::CHAN_BITS-1:0]                           n_alpha;
    logic [abvpp_pkg::NUM_CHAN-1:0][abvpp_pkg::BLEND_BITS-1:0] n_t;

    assign en3   = !r3_vld || i_rdy;
    assign en2   = !r2_vld || en3;
    assign en1   = !r1_vld || en2;
    assign o_rdy = en1;

    always_comb begin
        logic [9:0]  sum;
        logic [19:0] prod;
        sum  = {2'd0, i_opac[0]} + {2'd0, i_opac[1]} + {2'd0, i_opac[2]};
        prod = 20'(sum) * 20'(RECIP3);
        n_alpha = i_present ? prod[RECIP3_SHIFT+7:RECIP3_SHIFT] : abvpp_pkg::CHAN_MAX;
    end

    always_comb begin
        for (int c = 0; c < abvpp_pkg::NUM_CHAN; c++) begin
            n_t[c] = 16'(r1_c[c]) * 16'(r1_alpha)
                   + 16'(i_bg[c]) * 16'(abvpp_pkg::CHAN_MAX - r1_alpha);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            if (en1) begin
                r1_vld <= i_vld;
            end
            if (en2) begin
                r2_vld <= r1_vld;
            end
            if (en3) begin
                r3_vld <= r2_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_vld) begin
            r1_c     <= i_src;
            r1_alpha <= n_alpha;
        end
        if (en2 && r1_vld) begin
            r2_t <= n_t;
        end
        if (en3 && r2_vld) begin
            for (int c = 0; c < abvpp_pkg::NUM_CHAN; c++) begin
                r3_v[c] <= abvpp_pkg::div255(r2_t[c]);
            end
        end
    end

    assign o_vld = r3_vld;
    assign o_val = r3_v;

endmodule

>>> design/abvpp_scale.sv
// Field scaling and packing pipeline: scale to field width, place, merge.
module abvpp_scale (
    input  logic                                                     i_clk,
    input  logic                                                     i_rst_n,
    input  logic                                                     i_vld,
    input  logic [abvpp_pkg::NUM_CHAN-1:0][abvpp_pkg::CHAN_BITS-1:0] i_val,
    input  abvpp_pkg::t_chan_cfg [abvpp_pkg::NUM_CHAN-1:0]           i_place,
    input  logic                                                     i_rdy,
    output logic                                                     o_rdy,
    output logic                                                     o_vld,
    output logic [abvpp_pkg::MASK_BITS-1:0]                          o_word
);

    logic r4_vld, r5_vld, r6_vld;
    logic en4, en5, en6;

    logic [abvpp_pkg::NUM_CHAN-1:0][abvpp_pkg::MASK_BITS-1:0]  r4_pq;
    logic [abvpp_pkg::NUM_CHAN-1:0][abvpp_pkg::BLEND_BITS-1:0] r4_pr;
    logic [abvpp_pkg::NUM_CHAN-1:0][abvpp_pkg::MASK_BITS-1:0]  r5_scaled;
    logic [abvpp_pkg::MASK_BITS-1:0]                           r6_word;

    logic [abvpp_pkg::NUM_CHAN-1:0][abvpp_pkg::MASK_BITS-1:0]  n_pq;
    logic [abvpp_pkg::NUM_CHAN-1:0][abvpp_pkg::BLEND_BITS-1:0] n_pr;
    logic [abvpp_pkg::MASK_BITS-1:0]                           n_word;

    assign en6   = !r6_vld || i_rdy;
    assign en5   = !r5_vld || en6;
    assign en4   = !r4_vld || en5;
    assign o_rdy = en4;

    // value * field / 255 splits into value * (field / 255) plus
    // (value * (field mod 255)) / 255; the second product stays below 255 * 255.
    always_comb begin
        logic [32:0] pq_full;
        for (int c = 0; c < abvpp_pkg::NUM_CHAN; c++) begin
            pq_full = 33'(i_val[c]) * 33'(i_place[c].fq);
            n_pq[c] = pq_full[31:0];
            n_pr[c] = 16'(i_val[c]) * 16'(i_place[c].fr);
        end
    end

    always_comb begin
        n_word = '0;
        for (int c = 0; c < abvpp_pkg::NUM_CHAN; c++) begin
            n_word = n_word | ((r5_scaled[c] << i_place[c].shift) & i_place[c].mask);
        end
        n_word = n_word & abvpp_pkg::WORD_KEEP;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else begin
            if (en4) begin
                r4_vld <= i_vld;
            end
            if (en5) begin
                r5_vld <= r4_vld;
            end
            if (en6) begin
                r6_vld <= r5_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4 && i_vld) begin
            r4_pq <= n_pq;
            r4_pr <= n_pr;
        end
        if (en5 && r4_vld) begin
            for (int c = 0; c < abvpp_pkg::NUM_CHAN; c++) begin
                r5_scaled[c] <= r4_pq[c] + {24'd0, abvpp_pkg::div255(r4_pr[c])};
            end
        end
        if (en6 && r5_vld) begin
            r6_word <= n_word;
        end
    end

    assign o_vld  = r6_vld;
    assign o_word = r6_word;

endmodule

>>> design/alpha_blend_visual_pixel_pack.sv
// Top level of the alpha blend pixel packer: stream ports, configuration and pipeline.
//
// Each input transaction carries one 8-bit RGB source pixel and, flagged in tuser, one RGB
// mask pixel whose channel average is the alpha; without the flag alpha is full. Every
// channel is blended over the configured background color, scaled to the width of its
// configured field mask, placed at the mask's lowest set bit and merged into one 32-bit
// pixel word, one output transaction per input transaction, in order. The datapath is a
// six-stage pipeline (alpha, blend, divide by 255, field multiply, field divide, place and
// merge) with a valid bit per stage, so the block takes one pixel per clock unless the input
// is held off. A stall on the output holds the words in place and fills empty stages first;
// outside reset the input is only held off when all six stages are full and the output is
// stalled. The placement values derived from the field masks settle in registers after a
// configuration write, so the user must write registers only while no transaction is in
// flight; the block does not enforce this. Input transactions are refused while in reset.
module alpha_blend_visual_pixel_pack (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    // Pixel input.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // src_red, src_green, src_blue, opacity_red, opacity_green, opacity_blue
    input  logic [47:0] s_axis_tdata,
    // opacity_present
    input  logic [0:0]  s_axis_tuser,
    // Packed pixel output.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pixel_word
    output logic [31:0] m_axis_tdata
);

    logic [abvpp_pkg::NUM_CHAN-1:0][abvpp_pkg::CHAN_BITS-1:0] w_src;
    logic [abvpp_pkg::NUM_CHAN-1:0][abvpp_pkg::CHAN_BITS-1:0] w_opac;
    logic [abvpp_pkg::NUM_CHAN-1:0][abvpp_pkg::CHAN_BITS-1:0] w_bg;
    logic [abvpp_pkg::NUM_CHAN-1:0][abvpp_pkg::CHAN_BITS-1:0] w_val;
    abvpp_pkg::t_chan_cfg [abvpp_pkg::NUM_CHAN-1:0]           w_place;
    logic w_blend_rdy;
    logic w_val_vld;
    logic w_scale_rdy;

    // Unpack the input transaction; the source channels sit in the low bytes.
    assign w_src[abvpp_pkg::CH_RED]    = s_axis_tdata[7:0];
    assign w_src[abvpp_pkg::CH_GREEN]  = s_axis_tdata[15:8];
    assign w_src[abvpp_pkg::CH_BLUE]   = s_axis_tdata[23:16];
    assign w_opac[abvpp_pkg::CH_RED]   = s_axis_tdata[31:24];
    assign w_opac[abvpp_pkg::CH_GREEN] = s_axis_tdata[39:32];
    assign w_opac[abvpp_pkg::CH_BLUE]  = s_axis_tdata[47:40];

    assign s_axis_tready = w_blend_rdy && i_rst_n;

    abvpp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_bg        (w_bg),
        .o_place     (w_place)
    );

    abvpp_blend u_blend (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (s_axis_tvalid),
        .i_src     (w_src),
        .i_present (s_axis_tuser[0]),
        .i_opac    (w_opac),
        .i_bg      (w_bg),
        .i_rdy     (w_scale_rdy),
        .o_rdy     (w_blend_rdy),
        .o_vld     (w_val_vld),
        .o_val     (w_val)
    );

    abvpp_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_val_vld),
        .i_val   (w_val),
        .i_place (w_place),
        .i_rdy   (m_axis_tready),
        .o_rdy   (w_scale_rdy),
        .o_vld   (m_axis_tvalid),
        .o_word  (m_axis_tdata)
    );

endmodule

>>> design/abvpp_chk.sv
// Port-level checker for the alpha blend pixel packer, bound to the top level.
module abvpp_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // A stalled output transaction keeps its word.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output word changed while stalled");

    // Reset empties the pipeline.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // With the output stage empty nothing can back up, so the input is open.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input held off while output stage is empty");

    // Without output stalls a taken pixel reaches the output valid once it has passed every pipeline stage.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && m_axis_tready) ##1 m_axis_tready
        ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
        |=> m_axis_tvalid)
        else $error("result missing after pipeline latency");

endmodule

bind alpha_blend_visual_pixel_pack abvpp_chk u_abvpp_chk (.*);
